// ===== src/pkt_pkg.sv =====
// Shared constants, codes and types of the packet descriptor queue.
`timescale 1ns / 1ps
`default_nettype none

package pkt_pkg;

  localparam int DEPTH      = 256;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int HANDLE_W   = 16;
  localparam int LEN_W      = 16;
  localparam int ENTRY_W    = HANDLE_W + LEN_W;
  localparam int CNT_W      = 9;
  localparam int BYTES_W    = 24;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int POLICY_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_DROP = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_HEAD   = 2'd0,
    POL_TAIL   = 2'd1,
    POL_REFUSE = 2'd2,
    POL_NONE   = 2'd3
  } policy_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_REFUSED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_LIMIT  = 2'd0,
    REG_DROP_POLICY = 2'd1
  } reg_idx_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [CNT_W-1:0] limit;
    policy_t          policy;
  } cfg_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic                out_valid;
    logic [HANDLE_W-1:0] out_handle;
    logic [LEN_W-1:0]    out_bytes;
    logic                oversize;
    logic                drop_valid;
    logic [HANDLE_W-1:0] drop_handle;
    logic [LEN_W-1:0]    drop_bytes;
    logic [CNT_W-1:0]    count;
    logic [BYTES_W-1:0]  total_bytes;
  } result_t;

endpackage

`default_nettype wire

// ===== src/pkt_in_if.sv =====
// Input channel: one queue operation per beat.
`timescale 1ns / 1ps
`default_nettype none

interface pkt_in_if;
  import pkt_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HANDLE_W-1:0] handle;
  logic [LEN_W-1:0]    byte_len;
  logic [LEN_W-1:0]    max_bytes;

  modport source (output valid, output mode, output handle, output byte_len,
                  output max_bytes, input ready);
  modport sink   (input valid, input mode, input handle, input byte_len,
                  input max_bytes, output ready);
endinterface

`default_nettype wire

// ===== src/pkt_out_if.sv =====
// Result channel: one result beat per operation.
`timescale 1ns / 1ps
`default_nettype none

interface pkt_out_if;
  import pkt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic [LEN_W-1:0]    out_bytes;
  logic                oversize;
  logic                drop_valid;
  logic [HANDLE_W-1:0] drop_handle;
  logic [LEN_W-1:0]    drop_bytes;
  logic [CNT_W-1:0]    count;
  logic [BYTES_W-1:0]  total_bytes;

  modport source (output valid, output status, output out_valid, output out_handle,
                  output out_bytes, output oversize, output drop_valid,
                  output drop_handle, output drop_bytes, output count,
                  output total_bytes, input ready);
  modport sink   (input valid, input status, input out_valid, input out_handle,
                  input out_bytes, input oversize, input drop_valid,
                  input drop_handle, input drop_bytes, input count,
                  input total_bytes, output ready);
endinterface

`default_nettype wire

// ===== src/pkt_cfg_if.sv =====
// Configuration write channel: register index and data per beat.
`timescale 1ns / 1ps
`default_nettype none

interface pkt_cfg_if;
  import pkt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/packet_fifo_with_drop_policy.sv =====
// Packet descriptor FIFO with element limit, drop policy and running byte total.
//
// Channels: in_ch carries one operation per beat (mode, handle, byte_len,
// max_bytes); out_ch returns exactly one result beat per operation, in order;
// cfg_ch writes size_limit (index 0) or drop_policy (index 1) and is always
// ready. Write configuration only while no operation is outstanding.
// Descriptors live in a 256-entry RAM with a registered read.
// An operation is accepted and its head or tail slot read at the same edge;
// in the EXEC state that follows, the commit takes pointers, counters and
// the RAM write and loads the result register. The input is ready only in
// IDLE, so a new operation is not taken until the previous one has committed.
// The result register lets the next operation be accepted while a result
// waits; if the receiver still stalls when that operation would commit, the
// commit holds and the input stays not ready. After reset the queue is empty,
// size_limit is 256 and the policy is drop head; the RAM needs no clearing
// pass, since an unwritten entry that is read never reaches a result.
`timescale 1ns / 1ps
`default_nettype none

module packet_fifo_with_drop_policy (
  input  logic      clk,
  input  logic      rst_n,
  pkt_in_if.sink    in_ch,
  pkt_out_if.source out_ch,
  pkt_cfg_if.sink   cfg_ch
);
  import pkt_pkg::*;

  cfg_t               cfg;
  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  pkt_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pkt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  pkt_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== src/pkt_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pkt_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/pkt_cfg_regs.sv =====
// Configuration registers: size limit and drop policy.
`timescale 1ns / 1ps
`default_nettype none

module pkt_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  pkt_cfg_if.sink       cfg_ch,
  output pkt_pkg::cfg_t cfg
);
  import pkt_pkg::*;

  logic [CNT_W-1:0] size_limit_r;
  policy_t          drop_policy_r;
  logic             wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_limit_r  <= CNT_W'(DEPTH);
      drop_policy_r <= POL_HEAD;
    end else if (wr) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_SIZE_LIMIT:  size_limit_r  <= cfg_ch.data[CNT_W-1:0];
        REG_DROP_POLICY: drop_policy_r <= policy_t'(cfg_ch.data[POLICY_W-1:0]);
        default: ;
      endcase
    end
  end

  // zero or anything above the depth selects the full depth
  always_comb begin
    cfg.policy = drop_policy_r;
    if (size_limit_r == '0 || size_limit_r > CNT_W'(DEPTH)) begin
      cfg.limit = CNT_W'(DEPTH);
    end else begin
      cfg.limit = size_limit_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/pkt_ctrl.sv =====
// Queue sequencer: pointers, counters, read-modify-write of the entry RAM, result register.
`timescale 1ns / 1ps
`default_nettype none

module pkt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  pkt_in_if.sink                      in_ch,
  pkt_out_if.source                   out_ch,
  input  pkt_pkg::cfg_t               cfg,
  output logic                        ram_we,
  output logic [pkt_pkg::PTR_W-1:0]   ram_waddr,
  output logic [pkt_pkg::ENTRY_W-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [pkt_pkg::PTR_W-1:0]   ram_raddr,
  input  logic [pkt_pkg::ENTRY_W-1:0] ram_rdata
);
  import pkt_pkg::*;

  fsm_t                state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  mode_t               mode_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    maxb_r;
  logic                out_vld_r;
  result_t             res_r, res_nxt;

  logic                accept, fire;
  logic                full, empty, full_in, use_tail;
  logic                pop_head, pop_tail, push;
  logic [PTR_W-1:0]    tail_popped;
  entry_t              rd;

  assign accept  = in_ch.valid && in_ch.ready;
  assign full    = cnt_r >= cfg.limit;
  assign empty   = cnt_r == '0;
  assign full_in = full;
  assign rd      = entry_t'(ram_rdata);

  // Read the slot this item may pop; state is settled since the previous item
  // committed before this one was accepted, so no forwarding is needed.
  always_comb begin
    use_tail = 1'b0;
    unique case (mode_t'(in_ch.mode))
      MODE_ENQ:  use_tail = full_in && cfg.policy == POL_TAIL;
      MODE_DROP: use_tail = cfg.policy == POL_TAIL;
      default:   use_tail = 1'b0;
    endcase
  end

  assign ram_re    = accept;
  assign ram_raddr = use_tail ? tail_r - PTR_W'(1) : head_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (accept) state_nxt = FSM_EXEC;
      FSM_EXEC: if (fire) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready = 1'b0;
    fire        = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_ch.ready = 1'b1;
      FSM_EXEC: fire = !out_vld_r || out_ch.ready;
      default: ;
    endcase
  end

  // decide the operation from the fetched entry
  always_comb begin
    pop_head = 1'b0;
    pop_tail = 1'b0;
    push     = 1'b0;
    res_nxt  = '0;
    res_nxt.status = STAT_OK;
    unique case (mode_r)
      MODE_ENQ: begin
        if (!full) begin
          push = 1'b1;
        end else if (cfg.policy == POL_HEAD) begin
          pop_head = 1'b1;
          push     = 1'b1;
          res_nxt.status = STAT_DROPPED;
        end else if (cfg.policy == POL_TAIL) begin
          pop_tail = 1'b1;
          push     = 1'b1;
          res_nxt.status = STAT_DROPPED;
        end else begin
          res_nxt.status = STAT_REFUSED;
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          res_nxt.status = STAT_EMPTY;
        end else begin
          pop_head = 1'b1;
          res_nxt.out_valid  = 1'b1;
          res_nxt.out_handle = rd.handle;
          res_nxt.out_bytes  = rd.len;
          res_nxt.oversize   = rd.len > maxb_r;
        end
      end
      MODE_DROP: begin
        if (empty) begin
          res_nxt.status = STAT_EMPTY;
        end else if (cfg.policy == POL_TAIL) begin
          pop_tail = 1'b1;
          res_nxt.status = STAT_DROPPED;
        end else if (cfg.policy == POL_HEAD || cfg.policy == POL_REFUSE) begin
          pop_head = 1'b1;
          res_nxt.status = STAT_DROPPED;
        end else begin
          res_nxt.status = STAT_REFUSED;
        end
      end
      default: ;
    endcase

    if (mode_r != MODE_DEQ && (pop_head || pop_tail)) begin
      res_nxt.drop_valid  = 1'b1;
      res_nxt.drop_handle = rd.handle;
      res_nxt.drop_bytes  = rd.len;
    end

    tail_popped = pop_tail ? tail_r - PTR_W'(1) : tail_r;
    head_nxt    = pop_head ? head_r + PTR_W'(1) : head_r;
    tail_nxt    = push ? tail_popped + PTR_W'(1) : tail_popped;
    cnt_nxt     = cnt_r - CNT_W'(pop_head || pop_tail) + CNT_W'(push);
    bytes_nxt   = bytes_r - ((pop_head || pop_tail) ? BYTES_W'(rd.len) : '0)
                          + (push ? BYTES_W'(len_r) : '0);
    res_nxt.count       = cnt_nxt;
    res_nxt.total_bytes = bytes_nxt;
  end

  assign ram_we    = fire && push;
  assign ram_waddr = tail_popped;
  assign ram_wdata = ENTRY_W'({handle_r, len_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FSM_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      bytes_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        cnt_r     <= cnt_nxt;
        bytes_r   <= bytes_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mode_t'(in_ch.mode);
      handle_r <= in_ch.handle;
      len_r    <= in_ch.byte_len;
      maxb_r   <= in_ch.max_bytes;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.out_valid   = res_r.out_valid;
  assign out_ch.out_handle  = res_r.out_handle;
  assign out_ch.out_bytes   = res_r.out_bytes;
  assign out_ch.oversize    = res_r.oversize;
  assign out_ch.drop_valid  = res_r.drop_valid;
  assign out_ch.drop_handle = res_r.drop_handle;
  assign out_ch.drop_bytes  = res_r.drop_bytes;
  assign out_ch.count       = res_r.count;
  assign out_ch.total_bytes = res_r.total_bytes;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[PTR_W-1:0] == PTR_W'(tail_r - head_r))
    else $error("pointers disagree with held count");

  a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> bytes_r == '0)
    else $error("empty queue with nonzero byte total");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode_r == MODE_DEQ && cnt_r != '0 |=> cnt_r == CNT_W'($past(cnt_r) - 1'b1))
    else $error("dequeue did not decrement count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.status == STAT_EMPTY |-> cnt_r == '0)
    else $error("empty status on a nonempty queue");

endmodule

`default_nettype wire

// ===== sim/pkt_fifo_checker.sv =====
// Result checker for the packet descriptor queue: mirrors the queue, compares every result beat.
`timescale 1ns / 1ps

module pkt_fifo_checker (
  input  logic clk,
  input  logic rst_n,
  pkt_in_if    in_ch,
  pkt_out_if   out_ch,
  pkt_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   results_pending
);
  import pkt_pkg::*;

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   head_idx;
  logic [PTR_W-1:0]   tail_idx;
  int                 held;
  logic [BYTES_W-1:0] held_total;
  logic [CNT_W-1:0]   limit_reg;
  policy_t            policy_reg;
  result_t            expected_results [$];
  int                 fails = 0;
  int                 waiting = 0;

  assign mismatch_count  = fails;
  assign results_pending = waiting;

  function automatic entry_t take_head();
    entry_t e;
    e          = slots[head_idx];
    head_idx   = head_idx + 1'b1;
    held       = held - 1;
    held_total = held_total - BYTES_W'(e.len);
    return e;
  endfunction

  function automatic entry_t take_tail();
    entry_t e;
    tail_idx   = tail_idx - 1'b1;
    e          = slots[tail_idx];
    held       = held - 1;
    held_total = held_total - BYTES_W'(e.len);
    return e;
  endfunction

  // Advance the mirrored queue by one operation and return the result it must produce.
  function automatic result_t apply_queue_op(input logic [MODE_W-1:0]   mode_bits,
                                             input logic [HANDLE_W-1:0] handle,
                                             input logic [LEN_W-1:0]    len,
                                             input logic [LEN_W-1:0]    max_len);
    result_t r;
    entry_t  e;
    int      cap;
    logic    keep;
    r        = '0;
    r.status = STAT_OK;
    cap      = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
    keep     = 1'b1;
    case (mode_t'(mode_bits))
      MODE_ENQ: begin
        if (held >= cap) begin
          if (policy_reg == POL_HEAD || policy_reg == POL_TAIL) begin
            if (policy_reg == POL_HEAD) e = take_head();
            else e = take_tail();
            r.status      = STAT_DROPPED;
            r.drop_valid  = 1'b1;
            r.drop_handle = e.handle;
            r.drop_bytes  = e.len;
          end else begin
            keep     = 1'b0;
            r.status = STAT_REFUSED;
          end
        end
        if (keep && held < DEPTH) begin
          slots[tail_idx].handle = handle;
          slots[tail_idx].len    = len;
          tail_idx   = tail_idx + 1'b1;
          held       = held + 1;
          held_total = held_total + BYTES_W'(len);
        end
      end
      MODE_DEQ: begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          e            = take_head();
          r.out_valid  = 1'b1;
          r.out_handle = e.handle;
          r.out_bytes  = e.len;
          r.oversize   = (e.len > max_len);
        end
      end
      MODE_DROP: begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else if (policy_reg == POL_NONE) begin
          r.status = STAT_REFUSED;
        end else begin
          // forced drops take the head under the refuse policy
          if (policy_reg == POL_TAIL) e = take_tail();
          else e = take_head();
          r.status      = STAT_DROPPED;
          r.drop_valid  = 1'b1;
          r.drop_handle = e.handle;
          r.drop_bytes  = e.len;
        end
      end
      default: ;
    endcase
    r.count       = CNT_W'(held);
    r.total_bytes = held_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      head_idx   = '0;
      tail_idx   = '0;
      held       = 0;
      held_total = '0;
      limit_reg  = CNT_W'(DEPTH);
      policy_reg = POL_HEAD;
      expected_results.delete();
    end else begin
      // drain first: a result never belongs to the operation accepted at the same edge
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with no operation outstanding, expected none, actual status %0d",
                   $time, out_ch.status);
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("out_valid", want.out_valid, out_ch.out_valid);
          check_field("out_handle", want.out_handle, out_ch.out_handle);
          check_field("out_bytes", want.out_bytes, out_ch.out_bytes);
          check_field("oversize", want.oversize, out_ch.oversize);
          check_field("drop_valid", want.drop_valid, out_ch.drop_valid);
          check_field("drop_handle", want.drop_handle, out_ch.drop_handle);
          check_field("drop_bytes", want.drop_bytes, out_ch.drop_bytes);
          check_field("count", want.count, out_ch.count);
          check_field("total_bytes", want.total_bytes, out_ch.total_bytes);
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        expected_results.push_back(apply_queue_op(in_ch.mode, in_ch.handle,
                                                  in_ch.byte_len, in_ch.max_bytes));
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        if (cfg_ch.index == REG_SIZE_LIMIT) limit_reg = cfg_ch.data;
        else if (cfg_ch.index == REG_DROP_POLICY) policy_reg = policy_t'(cfg_ch.data[POLICY_W-1:0]);
      end
    end
    waiting = expected_results.size();
  end

endmodule

// ===== sim/packet_fifo_with_drop_policy_tb.sv =====
// Testbench top for the packet descriptor queue: clock, reset, traffic and verdict.
`timescale 1ns / 1ps

module packet_fifo_with_drop_policy_tb;
  import pkt_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   results_pending;
  int   tx_gap_pct = 0;
  int   rx_stall_pct = 0;
  int   phase_no = 0;
  int   quiet_cycles = 0;

  pkt_in_if  in_ch ();
  pkt_out_if out_ch ();
  pkt_cfg_if cfg_ch ();

  packet_fifo_with_drop_policy dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pkt_fifo_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  // Mostly no gap; when there is one, usually short and now and then long.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return LEN_W'($urandom_range(255));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  task automatic send_op(input mode_t m, input logic [HANDLE_W-1:0] h,
                         input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] max_len);
    int gap;
    gap = pick_gap(tx_gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.handle    <= h;
    in_ch.byte_len  <= len;
    in_ch.max_bytes <= max_len;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic send_random(input int enq_pct, input int deq_pct, input int drop_pct);
    int    pick;
    mode_t m;
    pick = $urandom_range(99);
    if (pick < enq_pct) m = MODE_ENQ;
    else if (pick < enq_pct + deq_pct) m = MODE_DEQ;
    else if (pick < enq_pct + deq_pct + drop_pct) m = MODE_DROP;
    else m = MODE_NONE;
    send_op(m, HANDLE_W'($urandom), pick_len(), pick_len());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold the input, wait for every outstanding result, then let the pipeline drain.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input int limit, input policy_t pol);
    settle();
    write_reg(REG_SIZE_LIMIT, CFG_DATA_W'(limit));
    write_reg(REG_DROP_POLICY, CFG_DATA_W'(pol));
  endtask

  task automatic run_phase(input int limit, input policy_t pol, input int items,
                           input int enq_pct, input int deq_pct, input int drop_pct);
    set_config(limit, pol);
    tx_gap_pct   = (phase_no % 3) * 25;
    rx_stall_pct = ((phase_no + 1) % 3) * 25;
    phase_no++;
    repeat (items) send_random(enq_pct, deq_pct, drop_pct);
  endtask

  // Result-side backpressure.
  initial begin : rx_side
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap(rx_stall_pct);
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_NONE;
    in_ch.handle    = '0;
    in_ch.byte_len  = '0;
    in_ch.max_bytes = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_SIZE_LIMIT;
    cfg_ch.data     = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    // empty queue, unused mode, field extremes and the oversize boundary
    send_op(MODE_DEQ, '0, '0, '1);
    send_op(MODE_DROP, '0, '0, '0);
    send_op(MODE_NONE, '1, '1, '1);
    send_op(MODE_ENQ, '0, '0, '0);
    send_op(MODE_ENQ, '1, '1, '0);
    send_op(MODE_ENQ, 16'h1234, 16'd100, '0);
    send_op(MODE_DEQ, '0, '0, '1);
    send_op(MODE_DEQ, '0, '0, '0);
    send_op(MODE_DEQ, '0, '0, 16'd100);
    send_op(MODE_ENQ, 16'hA5A5, '0, '0);
    // full queue: a zero-length head still counts as dropped
    set_config(1, POL_HEAD);
    send_op(MODE_ENQ, 16'h5A5A, 16'd7, '0);
    set_config(1, POL_TAIL);
    send_op(MODE_ENQ, 16'h0F0F, 16'd9, '0);
    send_op(MODE_DROP, '0, '0, '0);
    set_config(3, POL_REFUSE);
    repeat (3) send_op(MODE_ENQ, HANDLE_W'($urandom), LEN_W'($urandom), '0);
    send_op(MODE_ENQ, 16'hBEEF, 16'd1, '0);
    send_op(MODE_DROP, '0, '0, '0);
    set_config(3, POL_NONE);
    send_op(MODE_ENQ, 16'h1111, 16'd11, '0);
    send_op(MODE_ENQ, 16'h2222, 16'd22, '0);
    send_op(MODE_DROP, '0, '0, '0);
    // lower the limit below the count: enqueue drops one only, then trim by force drops
    set_config(1, POL_HEAD);
    send_op(MODE_ENQ, 16'h3333, 16'd33, '0);
    send_op(MODE_DROP, '0, '0, '0);
    send_op(MODE_DROP, '0, '0, '0);
    send_op(MODE_DEQ, '0, '0, 16'd7);
    settle();
    write_reg(REG_UNUSED, '1);

    run_phase(0,   POL_HEAD,   400, 90,  5,  3);
    run_phase(256, POL_TAIL,   150, 70, 15, 10);
    run_phase(300, POL_REFUSE, 150, 70, 15, 10);
    run_phase(511, POL_NONE,   100, 60, 10, 25);
    run_phase(8,   POL_HEAD,   200, 25, 10, 60);
    run_phase(1,   POL_TAIL,   150, 50, 30, 15);
    run_phase(2,   POL_REFUSE, 150, 50, 30, 15);
    run_phase(256, POL_HEAD,   250, 40, 50,  5);
    run_phase(17,  POL_NONE,   150, 55, 30, 10);
    run_phase(5,   POL_REFUSE, 150, 60, 20, 15);
    run_phase(256, POL_TAIL,   200, 75, 15,  5);

    settle();
    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== packet_fifo_with_drop_policy.f =====
src/pkt_pkg.sv
src/pkt_in_if.sv
src/pkt_out_if.sv
src/pkt_cfg_if.sv
src/pkt_ram.sv
src/pkt_cfg_regs.sv
src/pkt_ctrl.sv
src/packet_fifo_with_drop_policy.sv
sim/pkt_fifo_checker.sv
sim/packet_fifo_with_drop_policy_tb.sv
